// File: design/swm_pkg.sv
package swm_pkg;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int CFG_BITS = 5;
  localparam int FILL_BITS = 5;
  localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 5'd7;

  // up to this many entries the newest sample is the result
  localparam int SMALL_WINDOW = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRUNE,
    ST_INSERT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic prune;
    logic insert;
    logic flush;
  } cell_ctrl_t;

endpackage

// File: design/sliding_window_median.sv
// Running median over the newest window_size samples (capped at MAX_WINDOW), kept
// sorted in a chain of cells. For each accepted sample the cells first drop the
// entries aged out ahead of it (none while the window fills, one once it is full,
// more right after window_size is lowered), one entry per cycle, then take the new
// sample, and the result is read from the middle cell once more than SMALL_WINDOW
// entries are held, else it is the newest sample. With window_size zero the window
// is emptied and the sample is passed on. A result waits while the previous one is
// still stalled in the output register. The output register holds a result while the
// next sample is accepted, in the cycle after that result is loaded.
module sliding_window_median #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [swm_pkg::CFG_BITS-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     median_value,
  output logic [swm_pkg::FILL_BITS-1:0]     fill_level
);
  import swm_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LIM_W = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;

  state_t state, state_next;
  logic [CFG_BITS-1:0]           window_size;
  logic signed [SAMPLE_BITS-1:0] held;
  logic [CNT_BITS-1:0]           count, count_next;

  logic [LIM_W-1:0]              ws_wide;
  logic [LIM_W-1:0]              lim_wide;
  logic [CNT_BITS-1:0]           lim;
  logic                          pass;
  cell_ctrl_t                    ctrl;
  logic                          any_mark;
  logic signed [SAMPLE_BITS-1:0] med_value;
  logic [IDX_BITS-1:0]           med_idx;
  logic                          in_take;
  logic                          out_load;
  logic signed [SAMPLE_BITS-1:0] result;

  assign ws_wide = LIM_W'(window_size);
  assign lim_wide = (ws_wide > LIM_W'(MAX_WINDOW)) ? LIM_W'(MAX_WINDOW) : ws_wide;
  assign lim = CNT_BITS'(lim_wide);
  assign pass = (lim == '0);

  assign in_stall = (state != ST_IDLE);
  assign in_take = in_valid && !in_stall;
  assign med_idx = IDX_BITS'(count >> 1);
  assign result = (LIM_W'(count) > LIM_W'(SMALL_WINDOW)) ? med_value : held;

  swm_chain #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .sample   (held),
    .lim      (lim),
    .med_idx  (med_idx),
    .any_mark (any_mark),
    .med_value(med_value)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    ctrl = '0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_PRUNE;
        end
      end
      ST_PRUNE: begin
        if (pass) begin
          ctrl.flush = 1'b1;
          count_next = '0;
          state_next = ST_RESULT;
        end else if (any_mark) begin
          // drop the lowest aged-out entry, stay until none is left
          ctrl.prune = 1'b1;
          count_next = count - CNT_BITS'(1);
        end else begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        ctrl.insert = 1'b1;
        count_next = count + CNT_BITS'(1);
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      window_size <= WINDOW_SIZE_RESET;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        window_size <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held <= sample;
    end
    if (out_load) begin
      median_value <= result;
      fill_level <= FILL_BITS'(count);
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    LIM_W'(count) <= LIM_W'(MAX_WINDOW))
    else $error("window count above capacity");

  a_room_on_insert: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT) |-> (LIM_W'(count) < LIM_W'(MAX_WINDOW)))
    else $error("insert into a full chain");

  a_limit_kept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT) |-> (count <= lim))
    else $error("window holds more than the limit");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_PRUNE))
    else $error("accepted sample did not start processing");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (state == ST_IDLE)))
    else $error("result load lost");

endmodule

// File: design/swm_cell.sv
module swm_cell #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1),
  localparam int AGE_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swm_pkg::cell_ctrl_t           ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [CNT_BITS-1:0]           lim,
  input  logic signed [SAMPLE_BITS-1:0] lo_value,
  input  logic [AGE_BITS-1:0]           lo_age,
  input  logic                          lo_valid,
  input  logic                          lo_ins,
  input  logic                          lo_del,
  input  logic signed [SAMPLE_BITS-1:0] hi_value,
  input  logic [AGE_BITS-1:0]           hi_age,
  input  logic                          hi_valid,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [AGE_BITS-1:0]           age,
  output logic                          valid,
  output logic                          ins,
  output logic                          del
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] value_next;
  logic [AGE_BITS-1:0]           age_next;
  logic                          valid_next;
  logic [CNT_BITS-1:0]           age_p1;
  logic                          mark;

  assign age_p1 = CNT_BITS'(age) + CNT_BITS'(1);
  // entry would be too old once the new sample enters
  assign mark = valid && (age_p1 >= lim);
  // every cell at or above the lowest marked one pulls from above
  assign del = lo_del | mark;
  // new sample lands in the lowest cell that is greater or empty
  assign ins = !valid || (value > sample);

  always_comb begin
    value_next = value;
    age_next = age;
    valid_next = valid;
    if (ctrl.flush) begin
      valid_next = 1'b0;
    end else if (ctrl.prune) begin
      if (del) begin
        value_next = hi_value;
        age_next = hi_age;
        valid_next = hi_valid;
      end
    end else if (ctrl.insert) begin
      if (lo_ins) begin
        value_next = lo_value;
        age_next = lo_age + AGE_BITS'(1);
        valid_next = lo_valid;
      end else if (ins) begin
        value_next = sample;
        age_next = '0;
        valid_next = 1'b1;
      end else begin
        age_next = age + AGE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    age <= age_next;
  end

endmodule

// File: design/swm_chain.sv
module swm_chain #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
  localparam int CNT_BITS = $clog2(MAX_WINDOW + 1),
  localparam int AGE_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  localparam int IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swm_pkg::cell_ctrl_t           ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [CNT_BITS-1:0]           lim,
  input  logic [IDX_BITS-1:0]           med_idx,
  output logic                          any_mark,
  output logic signed [SAMPLE_BITS-1:0] med_value
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
  logic [AGE_BITS-1:0]           cell_age   [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         cell_valid;
  logic [MAX_WINDOW-1:0]         cell_ins;
  logic [MAX_WINDOW-1:0]         cell_del;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] lo_value;
    logic [AGE_BITS-1:0]           lo_age;
    logic                          lo_valid;
    logic                          lo_ins;
    logic                          lo_del;
    logic signed [SAMPLE_BITS-1:0] hi_value;
    logic [AGE_BITS-1:0]           hi_age;
    logic                          hi_valid;

    if (i == 0) begin : g_bottom
      assign lo_value = '0;
      assign lo_age = '0;
      assign lo_valid = 1'b0;
      assign lo_ins = 1'b0;
      assign lo_del = 1'b0;
    end else begin : g_lo
      assign lo_value = cell_value[i-1];
      assign lo_age = cell_age[i-1];
      assign lo_valid = cell_valid[i-1];
      assign lo_ins = cell_ins[i-1];
      assign lo_del = cell_del[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_top
      assign hi_value = '0;
      assign hi_age = '0;
      assign hi_valid = 1'b0;
    end else begin : g_hi
      assign hi_value = cell_value[i+1];
      assign hi_age = cell_age[i+1];
      assign hi_valid = cell_valid[i+1];
    end

    swm_cell #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .sample  (sample),
      .lim     (lim),
      .lo_value(lo_value),
      .lo_age  (lo_age),
      .lo_valid(lo_valid),
      .lo_ins  (lo_ins),
      .lo_del  (lo_del),
      .hi_value(hi_value),
      .hi_age  (hi_age),
      .hi_valid(hi_valid),
      .value   (cell_value[i]),
      .age     (cell_age[i]),
      .valid   (cell_valid[i]),
      .ins     (cell_ins[i]),
      .del     (cell_del[i])
    );
  end

  assign any_mark = cell_del[MAX_WINDOW-1];
  assign med_value = cell_value[med_idx];

endmodule
